>>> src/bmhq_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
`default_nettype none

package bmhq_pkg;

   localparam int PRIO_W    = 16;
   localparam int TAG_W     = 8;
   localparam int DATA_W    = PRIO_W + TAG_W;
   localparam int CNT_W     = 5;
   localparam int CNT_MAX   = (2 ** CNT_W) - 1;
   localparam int POS_W     = CNT_W + 1;
   localparam int DEPTH_DEF = 16;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
   } entry_type;

   typedef struct packed {
      status_type               status;
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
      logic [CNT_W-1:0]         count;
   } result_type;

endpackage

`default_nettype wire

>>> src/binary_max_heap_queue_top.sv
// Flow per word: a full insert or an empty extract goes straight to the result; an insert compares
// with each parent on its way up until it stops or lands in the root; an extract reads the root and
// the last entry, then moves down one level per compare until it stops at a leaf or on a compare.
// Throughput: one word at a time; next word accepted the cycle after the result enters the
// output register. Each level costs a RAM read (two on the way down) plus compare and write.
// Reset: entry count cleared, capacity limit set to 16; heap RAM is left uninitialized.
`default_nettype none

module binary_max_heap_queue_top #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bmhq_pkg::CNT_W-1:0]            csr_wr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_kind,
   input  wire logic signed [bmhq_pkg::PRIO_W-1:0]    req_task_priority,
   input  wire logic [bmhq_pkg::TAG_W-1:0]            req_task_tag,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_status,
   output logic signed [bmhq_pkg::PRIO_W-1:0]         rsp_out_priority,
   output logic [bmhq_pkg::TAG_W-1:0]                 rsp_out_tag,
   output logic [bmhq_pkg::CNT_W-1:0]                 rsp_entry_count
);

   import bmhq_pkg::*;

   localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] limit;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;
   logic             res_valid;
   logic             res_ready;
   result_type       res;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;
   assign limit  = (cap_ff > LIMIT_MAX) ? LIMIT_MAX : cap_ff;

   // output word register frees the core while the consumer stalls
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   bmhq_core #(
      .DEPTH (DEPTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_task_priority (req_task_priority),
      .req_task_tag      (req_task_tag),
      .limit             (limit),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res               (res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_out_priority = rsp_ff.prio;
   assign rsp_out_tag      = rsp_ff.tag;
   assign rsp_entry_count  = rsp_ff.count;

endmodule

`default_nettype wire

>>> src/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/bmhq_core.sv
// Heap sequencer: insert sift-up and extract sift-down over the entry RAM.
`default_nettype none

module bmhq_core #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_kind,
   input  wire logic signed [bmhq_pkg::PRIO_W-1:0]    req_task_priority,
   input  wire logic [bmhq_pkg::TAG_W-1:0]            req_task_tag,
   input  wire logic [bmhq_pkg::CNT_W-1:0]            limit,
   output logic                                       res_valid,
   input  wire logic                                  res_ready,
   output bmhq_pkg::result_type                       res
);

   import bmhq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_EX_ROOT = 9'b000000010,
      ST_EX_LAST = 9'b000000100,
      ST_DN_RDL  = 9'b000001000,
      ST_DN_RDR  = 9'b000010000,
      ST_DN_CMP  = 9'b000100000,
      ST_UP_RD   = 9'b001000000,
      ST_UP_CMP  = 9'b010000000,
      ST_FIN     = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   entry_type        cur_ff, cur_in;
   entry_type        kid_ff, kid_in;
   entry_type        out_ff, out_in;
   status_type       status_ff, status_in;

   logic             mem_we;
   logic             mem_re;
   logic [POS_W-1:0] rd_pos;
   entry_type        wr_entry;
   logic [DATA_W-1:0] mem_rdata;
   entry_type        rd_entry;

   logic [POS_W-1:0] cnt_ext;
   logic [POS_W-1:0] pos_lft;
   logic [POS_W-1:0] pos_rgt;
   logic [POS_W-1:0] pos_up;
   logic             take_l;
   logic             take_r;
   entry_type        best;

   assign rd_entry = entry_type'(mem_rdata);
   assign cnt_ext  = {1'b0, cnt_ff};
   assign pos_lft  = {pos_ff[POS_W-2:0], 1'b1};
   assign pos_rgt  = pos_lft + POS_W'(1);
   assign pos_up   = (pos_ff - POS_W'(1)) >> 1;

   // left child wins ties with the right child; each child wins only if strictly greater than the winner so far
   assign take_l = kid_ff.prio > cur_ff.prio;
   assign best   = take_l ? kid_ff : cur_ff;
   assign take_r = (pos_rgt < cnt_ext) && (rd_entry.prio > best.prio);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      kid_in    = kid_ff;
      out_in    = out_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      rd_pos    = '0;
      wr_entry  = cur_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               out_in = '0;
               if (req_kind == KIND_INSERT) begin
                  if (cnt_ff >= limit) begin
                     status_in = STAT_FULL;
                     state_in  = ST_FIN;
                  end else begin
                     status_in = STAT_OK;
                     cur_in    = '{prio: req_task_priority, tag: req_task_tag};
                     pos_in    = cnt_ext;
                     cnt_in    = cnt_ff + CNT_W'(1);
                     state_in  = ST_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = ST_FIN;
                  end else begin
                     status_in = STAT_OK;
                     mem_re    = 1'b1;
                     rd_pos    = '0;
                     cnt_in    = cnt_ff - CNT_W'(1);
                     state_in  = ST_EX_ROOT;
                  end
               end
            end
         end
         ST_EX_ROOT: begin
            // root word is on the read port; fetch the last entry
            out_in   = rd_entry;
            mem_re   = 1'b1;
            rd_pos   = cnt_ext;
            state_in = ST_EX_LAST;
         end
         ST_EX_LAST: begin
            cur_in   = rd_entry;
            pos_in   = '0;
            state_in = (cnt_ff == '0) ? ST_FIN : ST_DN_RDL;
         end
         ST_DN_RDL: begin
            if (pos_lft >= cnt_ext) begin
               mem_we   = 1'b1;
               state_in = ST_FIN;
            end else begin
               mem_re   = 1'b1;
               rd_pos   = pos_lft;
               state_in = ST_DN_RDR;
            end
         end
         ST_DN_RDR: begin
            kid_in = rd_entry;
            if (pos_rgt < cnt_ext) begin
               mem_re = 1'b1;
               rd_pos = pos_rgt;
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (take_r) begin
               wr_entry = rd_entry;
               pos_in   = pos_rgt;
               state_in = ST_DN_RDL;
            end else if (take_l) begin
               wr_entry = kid_ff;
               pos_in   = pos_lft;
               state_in = ST_DN_RDL;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_FIN;
            end else begin
               mem_re   = 1'b1;
               rd_pos   = pos_up;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (rd_entry.prio < cur_ff.prio) begin
               // parent drops into the hole, hole moves up
               wr_entry = rd_entry;
               pos_in   = pos_up;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = '{status: status_ff, prio: out_ff.prio, tag: out_ff.tag, count: cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      kid_ff    <= kid_in;
      out_ff    <= out_in;
      status_ff <= status_in;
   end

   bmhq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(pos_ff)),
      .wr_data (wr_entry),
      .rd_en   (mem_re),
      .rd_addr (AW'(rd_pos)),
      .rd_data (mem_rdata)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= DEPTH)
      else $error("entry count above heap depth");

   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (pos_ff < cnt_ext))
      else $error("heap write outside occupied range");

   a_rd_in_heap: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (rd_pos <= cnt_ext))
      else $error("heap read outside written range");

   a_cnt_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(cnt_ff))
      else $error("entry count changed without an accepted word");

endmodule

`default_nettype wire
